// ----- hw/rtl/vpr_pkg.sv -----
// Shared types, widths and codes for the viewport rectangle pipeline.
// No dependencies; all other files but vpr_div import this package.
package vpr_pkg;

   // Field and arithmetic widths
   localparam int FRAC      = 16;                 // fraction bits of an aspect ratio
   localparam int DIM_W     = 12;                 // frame dimension
   localparam int SCR_W     = 13;                 // screen dimension
   localparam int ASPECT_W  = 20;
   localparam int OFF_W     = 8;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 3;
   localparam int OUT_XY_W  = 14;

   localparam int D_W    = DIM_W + FRAC + 1;      // ratio as a quotient
   localparam int NA_W   = DIM_W + FRAC + 2;      // frame ratio dividend
   localparam int LHS_W  = SCR_W + FRAC;          // W scaled by one
   localparam int BP_W   = DIM_W + D_W;           // h * d
   localparam int RHS_W  = D_W + SCR_W;           // d * H
   localparam int BW_W   = BP_W + 1 - FRAC;       // rounded base width
   localparam int MSC_W  = 14;
   localparam int PROD_W = RHS_W + MSC_W;         // diff * tolerance scale
   localparam int CN_W   = SCR_W + 1;             // integer scale dividend
   localparam int L2N_W  = LHS_W + 2;             // letterbox height dividend
   localparam int L3N_W  = RHS_W + 2;             // letterbox offset dividend
   localparam int RW_W   = 2 * SCR_W;             // raw rectangle size
   localparam int XS_W   = RW_W + 2;              // raw rectangle position

   localparam logic [MSC_W-1:0] MATCH_SCALE = MSC_W'(10000);

   // Scaling modes
   localparam logic [2:0] MODE_NATIVE = 3'd0;
   localparam logic [2:0] MODE_CORE   = 3'd1;
   localparam logic [2:0] MODE_FRAME  = 3'd2;
   localparam logic [2:0] MODE_FULL   = 3'd3;
   localparam logic [2:0] MODE_CROP   = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_H = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ASPECT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HDMI     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION = 3'd7;

   // Decoded configuration; the user keeps it stable while requests are in flight (not enforced)
   typedef struct packed {
      logic [SCR_W-1:0]        scr_w;
      logic [SCR_W-1:0]        scr_h;
      logic [2:0]              mode;
      logic                    use_frame;
      logic [ASPECT_W-1:0]     core;
      logic signed [OFF_W-1:0] offx;
      logic signed [OFF_W-1:0] offy;
      logic                    swap;
   } cfg_type;

   // Frame dimensions after zero fix and swap
   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } ctx_type;

   // Everything the output stages need besides the quotients
   typedef struct packed {
      logic             fits;
      logic             match;
      logic             pil;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [SCR_W-1:0] bw;
      logic [SCR_W-1:0] pilw;
      logic [SCR_W-1:0] pilx;
   } fin_type;

   function automatic logic is_int_mode(input logic [2:0] mode);
      return (mode == MODE_NATIVE) || (mode == MODE_CROP);
   endfunction

   function automatic logic signed [OUT_XY_W-1:0] sat_xy(input logic signed [XS_W-1:0] v);
      logic signed [XS_W-1:0] hi;
      logic signed [XS_W-1:0] lo;
      hi = XS_W'(8191);
      lo = -XS_W'(8192);
      if (v > hi) return OUT_XY_W'(8191);
      if (v < lo) return -OUT_XY_W'(8192);
      return v[OUT_XY_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/viewport_present_rect.sv -----
// Viewport rectangle block: takes a frame size, returns the screen rectangle
// to draw it into, with integer, aspect-fit or stretched scaling.
//
// Request channel req_*: frame width and height, valid/ready. Response
// channel rsp_*: rect x, y, w, h and the swapped flag, valid/ready.
// Configuration csr_*: write enable, register index, data; write only while
// no request is in flight.
//
// From accept to rsp_valid: capture register, frame ratio divider (one quotient
// bit per stage over 29 stages), stages M, P, Q, back-half dividers (13), F1,
// result register. A new request is accepted every cycle unless rsp_* stalls.
//
// Every stage moves on one common enable; when rsp_valid is high and
// rsp_ready low, the whole pipeline holds and req_ready drops, so nothing is
// lost or repeated. Reset clears all valid bits and loads the register
// defaults (640x480, core aspect mode, no offset, no rotation).
module viewport_present_rect (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [vpr_pkg::DIM_W-1:0]          req_frame_width,
   input  logic [vpr_pkg::DIM_W-1:0]          req_frame_height,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vpr_pkg::OUT_XY_W-1:0] rsp_rect_x,
   output logic signed [vpr_pkg::OUT_XY_W-1:0] rsp_rect_y,
   output logic [vpr_pkg::SCR_W-1:0]          rsp_rect_w,
   output logic [vpr_pkg::SCR_W-1:0]          rsp_rect_h,
   output logic                               rsp_dims_swapped,
   input  logic                               csr_we,
   input  logic [vpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vpr_pkg::CSR_W-1:0]          csr_wdata
);
   import vpr_pkg::*;

   logic [SCR_W-1:0]    scr_w_ff;
   logic [SCR_W-1:0]    scr_h_ff;
   logic [2:0]          mode_ff;
   logic [ASPECT_W-1:0] aspect_ff;
   logic                hdmi_ff;
   logic [OFF_W-1:0]    offx_ff;
   logic [OFF_W-1:0]    offy_ff;
   logic [1:0]          rot_ff;

   cfg_type             cfg;
   logic [2:0]          mode_lim;
   logic                en;

   logic                s0_valid_ff;
   ctx_type             s0_ctx_ff;
   ctx_type             s0_ctx_in;
   logic [DIM_W-1:0]    fw;
   logic [DIM_W-1:0]    fh;

   logic                a_valid;
   logic [D_W-1:0]      a_quo;
   ctx_type             a_ctx;

   logic                b_valid;
   logic [CN_W-1:0]     sx_num;
   logic [SCR_W-1:0]    sx_den;
   logic [CN_W-1:0]     sy_num;
   logic [DIM_W-1:0]    sy_den;
   logic [L2N_W-1:0]    lh_num;
   logic [D_W:0]        lh_den;
   logic [L3N_W-1:0]    ly_num;
   logic [D_W+1:0]      ly_den;
   fin_type             b_side;

   logic                c_valid;
   fin_type             c_side;
   logic [SCR_W-1:0]    sx_quo;
   logic [SCR_W-1:0]    sy_quo;
   logic [SCR_W-1:0]    lh_quo;
   logic [SCR_W-1:0]    ly_quo;

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff  <= SCR_W'(640);
         scr_h_ff  <= SCR_W'(480);
         mode_ff   <= MODE_CORE;
         aspect_ff <= '0;
         hdmi_ff   <= 1'b0;
         offx_ff   <= '0;
         offy_ff   <= '0;
         rot_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCREEN_W: scr_w_ff  <= csr_wdata[SCR_W-1:0];
            REG_SCREEN_H: scr_h_ff  <= csr_wdata[SCR_W-1:0];
            REG_MODE:     mode_ff   <= csr_wdata[2:0];
            REG_ASPECT:   aspect_ff <= csr_wdata[ASPECT_W-1:0];
            REG_HDMI:     hdmi_ff   <= csr_wdata[0];
            REG_OFFSET_X: offx_ff   <= csr_wdata[OFF_W-1:0];
            REG_OFFSET_Y: offy_ff   <= csr_wdata[OFF_W-1:0];
            REG_ROTATION: rot_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // decode configuration: zero screen sizes act as one, unused modes as core, crop with HDMI as native
   assign mode_lim = (mode_ff > MODE_CROP) ? MODE_CORE : mode_ff;

   always_comb begin
      cfg.scr_w     = (scr_w_ff == '0) ? SCR_W'(1) : scr_w_ff;
      cfg.scr_h     = (scr_h_ff == '0) ? SCR_W'(1) : scr_h_ff;
      cfg.mode      = (mode_lim == MODE_CROP && hdmi_ff) ? MODE_NATIVE : mode_lim;
      cfg.use_frame = (mode_lim == MODE_FRAME) || (aspect_ff == '0);
      cfg.core      = aspect_ff;
      cfg.offx      = $signed(offx_ff);
      cfg.offy      = $signed(offy_ff);
      cfg.swap      = rot_ff[0];
   end

   // one enable for the whole pipeline
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 0: capture request, fix zero sizes, swap on odd rotation
   assign fw = (req_frame_width == '0) ? DIM_W'(1) : req_frame_width;
   assign fh = (req_frame_height == '0) ? DIM_W'(1) : req_frame_height;

   always_comb begin
      s0_ctx_in.w = cfg.swap ? fh : fw;
      s0_ctx_in.h = cfg.swap ? fw : fh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ctx_ff <= s0_ctx_in;
      end
   end

   // frame ratio: round(w * one / h)
   vpr_div #(
      .NUM_W (NA_W),
      .DEN_W (DIM_W + 1),
      .QUO_W (D_W),
      .SIDE_W($bits(ctx_type))
   ) u_div_ratio (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s0_valid_ff),
      .in_num   ((NA_W'(s0_ctx_ff.w) << (FRAC + 1)) + NA_W'(s0_ctx_ff.h)),
      .in_den   ({s0_ctx_ff.h, 1'b0}),
      .in_side  (s0_ctx_ff),
      .out_valid(a_valid),
      .out_quo  (a_quo),
      .out_side (a_ctx)
   );

   vpr_mid u_mid (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg),
      .in_valid (a_valid),
      .in_quo   (a_quo),
      .in_ctx   (a_ctx),
      .out_valid(b_valid),
      .sx_num   (sx_num),
      .sx_den   (sx_den),
      .sy_num   (sy_num),
      .sy_den   (sy_den),
      .lh_num   (lh_num),
      .lh_den   (lh_den),
      .ly_num   (ly_num),
      .ly_den   (ly_den),
      .out_side (b_side)
   );

   // integer scale along x; carries the side information
   vpr_div #(
      .NUM_W (CN_W),
      .DEN_W (SCR_W),
      .QUO_W (SCR_W),
      .SIDE_W($bits(fin_type))
   ) u_div_sx (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_valid),
      .in_num   (sx_num),
      .in_den   (sx_den),
      .in_side  (b_side),
      .out_valid(c_valid),
      .out_quo  (sx_quo),
      .out_side (c_side)
   );

   // integer scale along y
   vpr_div #(
      .NUM_W (CN_W),
      .DEN_W (DIM_W),
      .QUO_W (SCR_W),
      .SIDE_W(1)
   ) u_div_sy (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_valid),
      .in_num   (sy_num),
      .in_den   (sy_den),
      .in_side  (1'b0),
      .out_valid(),
      .out_quo  (sy_quo),
      .out_side ()
   );

   // letterbox height
   vpr_div #(
      .NUM_W (L2N_W),
      .DEN_W (D_W + 1),
      .QUO_W (SCR_W),
      .SIDE_W(1)
   ) u_div_lh (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_valid),
      .in_num   (lh_num),
      .in_den   (lh_den),
      .in_side  (1'b0),
      .out_valid(),
      .out_quo  (lh_quo),
      .out_side ()
   );

   // letterbox top edge
   vpr_div #(
      .NUM_W (L3N_W),
      .DEN_W (D_W + 2),
      .QUO_W (SCR_W),
      .SIDE_W(1)
   ) u_div_ly (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_valid),
      .in_num   (ly_num),
      .in_den   (ly_den),
      .in_side  (1'b0),
      .out_valid(),
      .out_quo  (ly_quo),
      .out_side ()
   );

   vpr_out u_out (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg),
      .in_valid (c_valid),
      .in_side  (c_side),
      .sx_quo   (sx_quo),
      .sy_quo   (sy_quo),
      .lh_quo   (lh_quo),
      .ly_quo   (ly_quo),
      .out_valid(rsp_valid),
      .out_x    (rsp_rect_x),
      .out_y    (rsp_rect_y),
      .out_w    (rsp_rect_w),
      .out_h    (rsp_rect_h)
   );

   assign rsp_dims_swapped = cfg.swap;

   // a stalled response freezes the input side too
   a_stall_holds_input: assert property (@(posedge clock)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while response stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // fullscreen without offsets covers the whole screen
   a_full_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cfg.mode == MODE_FULL && cfg.offx == '0 && cfg.offy == '0
      |-> rsp_rect_w == cfg.scr_w && rsp_rect_h == cfg.scr_h
          && rsp_rect_x == '0 && rsp_rect_y == '0)
      else $error("fullscreen rectangle does not cover screen");

   // pillarbox or letterbox never exceeds the screen before offsets
   a_aspect_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cfg.mode == MODE_CORE || cfg.mode == MODE_FRAME)
      |-> rsp_rect_w <= cfg.scr_w && rsp_rect_h <= cfg.scr_h)
      else $error("aspect fit rectangle larger than screen");

endmodule

// ----- hw/rtl/vpr_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; a side vector travels alongside each request.
module vpr_div #(
   parameter int NUM_W  = 16,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 8,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [QUO_W-1:0]  val_ff;
   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic              prv_valid;
      logic [NUM_W-1:0]  prv_rem;
      logic [DEN_W-1:0]  prv_den;
      logic [QUO_W-1:0]  prv_quo;
      logic [SIDE_W-1:0] prv_side;
      logic [CMP_W-1:0]  rem_ext;
      logic [CMP_W-1:0]  den_sh;
      logic              take;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (j == 0) begin : g_first
         assign prv_valid = in_valid;
         assign prv_rem   = in_num;
         assign prv_den   = in_den;
         assign prv_quo   = '0;
         assign prv_side  = in_side;
      end else begin : g_next
         assign prv_valid = val_ff[j-1];
         assign prv_rem   = rem_ff[j-1];
         assign prv_den   = den_ff[j-1];
         assign prv_quo   = quo_ff[j-1];
         assign prv_side  = side_ff[j-1];
      end

      // try subtracting the divisor at this bit weight
      assign rem_ext = CMP_W'(prv_rem);
      assign den_sh  = CMP_W'(prv_den) << (QUO_W - 1 - j);
      assign take    = rem_ext >= den_sh;
      assign rem_in  = take ? NUM_W'(rem_ext - den_sh) : prv_rem;
      assign quo_in  = prv_quo | (take ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);

      // advance valid with the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[j] <= 1'b0;
         end else if (en) begin
            val_ff[j] <= prv_valid;
         end
      end

      // advance payload
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= prv_den;
            quo_ff[j]  <= quo_in;
            side_ff[j] <= prv_side;
         end
      end
   end

   assign out_valid = val_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ----- hw/rtl/vpr_mid.sv -----
// Ratio selection, base width, box test and divider operand setup.
// Depends on vpr_pkg; feeds the four parallel dividers of the back half.
module vpr_mid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  vpr_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   input  logic [vpr_pkg::D_W-1:0]     in_quo,
   input  vpr_pkg::ctx_type            in_ctx,
   output logic                        out_valid,
   output logic [vpr_pkg::CN_W-1:0]    sx_num,
   output logic [vpr_pkg::SCR_W-1:0]   sx_den,
   output logic [vpr_pkg::CN_W-1:0]    sy_num,
   output logic [vpr_pkg::DIM_W-1:0]   sy_den,
   output logic [vpr_pkg::L2N_W-1:0]   lh_num,
   output logic [vpr_pkg::D_W:0]       lh_den,
   output logic [vpr_pkg::L3N_W-1:0]   ly_num,
   output logic [vpr_pkg::D_W+1:0]     ly_den,
   output vpr_pkg::fin_type            out_side
);
   import vpr_pkg::*;

   logic [LHS_W-1:0] lhs;
   logic [D_W-1:0]   d_sel;
   logic             crop;

   // stage M
   logic             m_valid_ff;
   ctx_type          m_ctx_ff;
   logic [D_W-1:0]   m_d_ff;
   logic [BP_W-1:0]  m_bwp_ff;
   logic [RHS_W-1:0] m_rhs_ff;
   // stage P
   logic             p_valid_ff;
   ctx_type          p_ctx_ff;
   logic [D_W-1:0]   p_d_ff;
   logic [BW_W-1:0]  p_bw_ff;
   logic             p_pil_ff;
   logic [RHS_W-1:0] p_diff_ff;
   logic [SCR_W-1:0] p_pilw_ff;
   logic [BP_W:0]    bw_sum;
   logic [BW_W-1:0]  bw_in;
   logic [RHS_W:0]   pilw_sum;
   // stage Q
   logic             q_valid_ff;
   ctx_type          q_ctx_ff;
   logic [D_W-1:0]   q_d_ff;
   logic [SCR_W-1:0] q_bw_ff;
   logic             q_fits_ff;
   logic             q_pil_ff;
   logic [RHS_W-1:0] q_diff_ff;
   logic [SCR_W-1:0] q_pilw_ff;
   logic [SCR_W-1:0] q_pilx_ff;
   logic [PROD_W-1:0] q_prod_ff;
   logic [RHS_W:0]   pilx_sum;
   logic [PROD_W-1:0] match_lim;

   assign lhs   = LHS_W'(cfg.scr_w) << FRAC;
   assign d_sel = cfg.use_frame ? in_quo : D_W'(cfg.core);
   assign crop  = (cfg.mode == MODE_CROP);

   // stage M: pick the ratio, form h*d and d*H
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ctx_ff <= in_ctx;
         m_d_ff   <= d_sel;
         m_bwp_ff <= BP_W'(in_ctx.h) * BP_W'(d_sel);
         m_rhs_ff <= RHS_W'(d_sel) * RHS_W'(cfg.scr_h);
      end
   end

   // stage P: round the base width, compare W*one against d*H, form diff and pillarbox width
   assign bw_sum   = (BP_W + 1)'(m_bwp_ff) + (BP_W + 1)'(1 << (FRAC - 1));
   assign bw_in    = BW_W'(bw_sum >> FRAC);
   assign pilw_sum = (RHS_W + 1)'(m_rhs_ff) + (RHS_W + 1)'(1 << (FRAC - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ctx_ff  <= m_ctx_ff;
         p_d_ff    <= m_d_ff;
         p_bw_ff   <= (bw_in == '0) ? BW_W'(1) : bw_in;
         p_pil_ff  <= RHS_W'(lhs) > m_rhs_ff;
         p_diff_ff <= (RHS_W'(lhs) > m_rhs_ff) ? RHS_W'(lhs) - m_rhs_ff
                                               : m_rhs_ff - RHS_W'(lhs);
         p_pilw_ff <= SCR_W'(pilw_sum >> FRAC);
      end
   end

   // stage Q: fit test, tolerance product, pillarbox offset
   assign pilx_sum = (RHS_W + 1)'(p_diff_ff) + (RHS_W + 1)'(1 << FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (en) begin
         q_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ctx_ff  <= p_ctx_ff;
         q_d_ff    <= p_d_ff;
         q_bw_ff   <= SCR_W'(p_bw_ff);
         q_fits_ff <= (p_bw_ff <= BW_W'(cfg.scr_w)) && (SCR_W'(p_ctx_ff.h) <= cfg.scr_h);
         q_pil_ff  <= p_pil_ff;
         q_diff_ff <= p_diff_ff;
         q_pilw_ff <= p_pilw_ff;
         q_pilx_ff <= SCR_W'(pilx_sum >> (FRAC + 1));
         q_prod_ff <= PROD_W'(p_diff_ff) * PROD_W'(MATCH_SCALE);
      end
   end

   // divider operands and side information
   assign match_lim = PROD_W'(cfg.scr_h) << FRAC;

   assign out_valid = q_valid_ff;
   assign sx_num = crop ? CN_W'(cfg.scr_w) + CN_W'(q_bw_ff) - CN_W'(1) : CN_W'(cfg.scr_w);
   assign sx_den = q_bw_ff;
   assign sy_num = crop ? CN_W'(cfg.scr_h) + CN_W'(q_ctx_ff.h) - CN_W'(1)
                        : CN_W'(cfg.scr_h);
   assign sy_den = q_ctx_ff.h;
   assign lh_num = (L2N_W'(lhs) << 1) + L2N_W'(q_d_ff);
   assign lh_den = (D_W + 1)'(q_d_ff) << 1;
   assign ly_num = (L3N_W'(q_diff_ff) << 1) + (L3N_W'(q_d_ff) << 1);
   assign ly_den = (D_W + 2)'(q_d_ff) << 2;

   always_comb begin
      out_side.fits  = q_fits_ff;
      out_side.match = q_prod_ff < match_lim;
      out_side.pil   = q_pil_ff;
      out_side.w     = q_ctx_ff.w;
      out_side.h     = q_ctx_ff.h;
      out_side.bw    = q_bw_ff;
      out_side.pilw  = q_pilw_ff;
      out_side.pilx  = q_pilx_ff;
   end

endmodule

// ----- hw/rtl/vpr_out.sv -----
// Mode selection, centering, user offsets, saturation and result register.
// Depends on vpr_pkg; takes the four back-half quotients.
module vpr_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  vpr_pkg::cfg_type                   cfg,
   input  logic                               in_valid,
   input  vpr_pkg::fin_type                   in_side,
   input  logic [vpr_pkg::SCR_W-1:0]          sx_quo,
   input  logic [vpr_pkg::SCR_W-1:0]          sy_quo,
   input  logic [vpr_pkg::SCR_W-1:0]          lh_quo,
   input  logic [vpr_pkg::SCR_W-1:0]          ly_quo,
   output logic                               out_valid,
   output logic signed [vpr_pkg::OUT_XY_W-1:0] out_x,
   output logic signed [vpr_pkg::OUT_XY_W-1:0] out_y,
   output logic [vpr_pkg::SCR_W-1:0]          out_w,
   output logic [vpr_pkg::SCR_W-1:0]          out_h
);
   import vpr_pkg::*;

   logic                   int_m;
   logic [SCR_W-1:0]       s;
   logic [RW_W-1:0]        rw_in;
   logic [RW_W-1:0]        rh_in;
   logic [SCR_W-1:0]       x_in;
   logic [SCR_W-1:0]       y_in;

   logic                   f_valid_ff;
   logic [RW_W-1:0]        f_rw_ff;
   logic [RW_W-1:0]        f_rh_ff;
   logic [SCR_W-1:0]       f_x_ff;
   logic [SCR_W-1:0]       f_y_ff;

   logic signed [XS_W-1:0] xc;
   logic signed [XS_W-1:0] yc;
   logic signed [XS_W-1:0] xt;
   logic signed [XS_W-1:0] yt;
   logic signed [XS_W-1:0] x_base;
   logic signed [XS_W-1:0] y_base;
   logic signed [XS_W-1:0] x_sum;
   logic signed [XS_W-1:0] y_sum;

   logic                          valid_ff;
   logic signed [OUT_XY_W-1:0]    x_ff;
   logic signed [OUT_XY_W-1:0]    y_ff;
   logic [SCR_W-1:0]              w_ff;
   logic [SCR_W-1:0]              h_ff;

   assign int_m = is_int_mode(cfg.mode);
   assign s     = (sx_quo < sy_quo) ? sx_quo : sy_quo;

   // stage F1: rectangle size and box offset by mode
   always_comb begin
      rw_in = RW_W'(cfg.scr_w);
      rh_in = RW_W'(cfg.scr_h);
      x_in  = '0;
      y_in  = '0;
      if (int_m) begin
         if (in_side.fits) begin
            rw_in = RW_W'(in_side.bw) * RW_W'(s);
            rh_in = RW_W'(in_side.h) * RW_W'(s);
         end else begin
            rw_in = RW_W'(in_side.w);
            rh_in = RW_W'(in_side.h);
         end
      end else if (cfg.mode == MODE_FULL || in_side.match) begin
         rw_in = RW_W'(cfg.scr_w);
      end else if (in_side.pil) begin
         rw_in = RW_W'(in_side.pilw);
         x_in  = in_side.pilx;
      end else begin
         rh_in = RW_W'(lh_quo);
         y_in  = ly_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_rw_ff <= rw_in;
         f_rh_ff <= rh_in;
         f_x_ff  <= x_in;
         f_y_ff  <= y_in;
      end
   end

   // stage F2: center in the integer modes, truncating toward zero, then add the x offset and subtract the y offset
   assign xc = $signed(XS_W'(cfg.scr_w)) - $signed(XS_W'(f_rw_ff));
   assign yc = $signed(XS_W'(cfg.scr_h)) - $signed(XS_W'(f_rh_ff));
   assign xt = xc + $signed({{(XS_W-1){1'b0}}, xc[XS_W-1]});
   assign yt = yc + $signed({{(XS_W-1){1'b0}}, yc[XS_W-1]});

   assign x_base = int_m ? (xt >>> 1) : $signed(XS_W'(f_x_ff));
   assign y_base = int_m ? (yt >>> 1) : $signed(XS_W'(f_y_ff));
   assign x_sum  = x_base + XS_W'(cfg.offx);
   assign y_sum  = y_base - XS_W'(cfg.offy);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= sat_xy(x_sum);
         y_ff <= sat_xy(y_sum);
         w_ff <= (f_rw_ff > RW_W'(8191)) ? SCR_W'(8191) : SCR_W'(f_rw_ff);
         h_ff <= (f_rh_ff > RW_W'(8191)) ? SCR_W'(8191) : SCR_W'(f_rh_ff);
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_w     = w_ff;
   assign out_h     = h_ff;

endmodule

// ----- test/viewport_present_rect_test.sv -----
// Testbench for viewport_present_rect: directed table then random frame sizes,
// each response checked against its typed rectangle or an in-bench rectangle predictor.
// Depends on vpr_pkg and the viewport_present_rect RTL.
module viewport_present_rect_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vpr_pkg::*;

   localparam int LATENCY = 48;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DIM_W-1:0] req_frame_width = '0;
   logic [DIM_W-1:0] req_frame_height = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_XY_W-1:0] rsp_rect_x;
   logic signed [OUT_XY_W-1:0] rsp_rect_y;
   logic [SCR_W-1:0] rsp_rect_w;
   logic [SCR_W-1:0] rsp_rect_h;
   logic rsp_dims_swapped;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   typedef struct packed {
      logic [OUT_XY_W-1:0] x;
      logic [OUT_XY_W-1:0] y;
      logic [SCR_W-1:0] w;
      logic [SCR_W-1:0] h;
      logic swapped;
   } rect_type;

   typedef struct {
      logic [DIM_W-1:0] fw;
      logic [DIM_W-1:0] fh;
      logic typed;
      rect_type rect;
   } row_type;

   // Shadow copy of the registers
   logic [SCR_W-1:0] shadow_scr_w;
   logic [SCR_W-1:0] shadow_scr_h;
   logic [2:0] shadow_mode;
   logic [ASPECT_W-1:0] shadow_aspect;
   logic shadow_hdmi;
   logic [OFF_W-1:0] shadow_offx;
   logic [OFF_W-1:0] shadow_offy;
   logic [1:0] shadow_rot;

   rect_type pending_rects[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int rsp_wait = 0;
   bit stim_done = 1'b0;

   viewport_present_rect uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint round_div(longint num, longint den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Compute the destination rectangle for one frame size
   function automatic rect_type predict_rect(logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh);
      longint one, sw, sh, w, h, t, d, x, y, rw, rh, bw, sx, sy, s, lhs, rhs, diff;
      logic [2:0] mode;
      logic swap;
      rect_type r;
      one = 64'd1 << FRAC;
      sw = shadow_scr_w;
      sh = shadow_scr_h;
      w = fw;
      h = fh;
      x = 0;
      y = 0;
      mode = shadow_mode;
      swap = shadow_rot[0];
      if (sw == 0) sw = 1;
      if (sh == 0) sh = 1;
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      if (swap) begin
         t = w; w = h; h = t;
      end
      if (mode > MODE_CROP) mode = MODE_CORE;
      if (mode == MODE_CROP && shadow_hdmi) mode = MODE_NATIVE;
      if (mode == MODE_FRAME || shadow_aspect == 0) d = round_div(w * one, h);
      else d = shadow_aspect;
      rw = sw;
      rh = sh;
      if (mode == MODE_NATIVE || mode == MODE_CROP) begin
         bw = round_div(h * d, one);
         if (bw == 0) bw = 1;
         if (sw >= bw && sh >= h) begin
            if (mode == MODE_CROP) begin
               sx = (sw + bw - 1) / bw;
               sy = (sh + h - 1) / h;
            end else begin
               sx = sw / bw;
               sy = sh / h;
            end
            s = sx < sy ? sx : sy;
            rw = bw * s;
            rh = h * s;
         end else begin
            rw = w;
            rh = h;
         end
         x = (sw - rw) / 2;
         y = (sh - rh) / 2;
      end else if (mode != MODE_FULL) begin
         lhs = sw * one;
         rhs = d * sh;
         diff = lhs > rhs ? lhs - rhs : rhs - lhs;
         if (diff * 10000 < sh * one) begin
            // ratios match, keep full screen
         end else if (lhs > rhs) begin
            rw = round_div(rhs, one);
            x = round_div(lhs - rhs, 2 * one);
         end else begin
            rh = round_div(lhs, d);
            y = round_div(rhs - lhs, 2 * d);
         end
      end
      x += longint'($signed(shadow_offx));
      y -= longint'($signed(shadow_offy));
      r.x = OUT_XY_W'(clamp(x, -8192, 8191));
      r.y = OUT_XY_W'(clamp(y, -8192, 8191));
      r.w = SCR_W'(clamp(rw, 0, 8191));
      r.h = SCR_W'(clamp(rh, 0, 8191));
      r.swapped = swap;
      return r;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SCREEN_W: shadow_scr_w = data[SCR_W-1:0];
         REG_SCREEN_H: shadow_scr_h = data[SCR_W-1:0];
         REG_MODE:     shadow_mode = data[2:0];
         REG_ASPECT:   shadow_aspect = data[ASPECT_W-1:0];
         REG_HDMI:     shadow_hdmi = data[0];
         REG_OFFSET_X: shadow_offx = data[OFF_W-1:0];
         REG_OFFSET_Y: shadow_offy = data[OFF_W-1:0];
         default:      shadow_rot = data[1:0];
      endcase
   endtask

   // Drop the request, drain responses, then let the pipeline settle before a write
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_request(logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
                               logic typed, rect_type rect);
      rect_type exp_rect;
      int gap;
      gap = $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
      // hold valid high across back-to-back requests, drop it only for a gap
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      exp_rect = typed ? rect : predict_rect(fw, fh);
      req_valid <= 1'b1;
      req_frame_width <= fw;
      req_frame_height <= fh;
      do @(posedge clock); while (!req_ready);
      pending_rects.push_back(exp_rect);
   endtask

   // Response side: per-response stall, check at accept
   always @(posedge clock) begin
      rect_type got, want;
      int wait_n;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h, rsp_dims_swapped};
            if (pending_rects.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = pending_rects.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rect mismatch: expected %p, got %p", want, got);
               end
            end
            wait_n = $urandom_range(0, 6);
            rsp_wait <= wait_n;
            rsp_ready <= (wait_n == 0);
         end else if (rsp_wait > 1) begin
            rsp_wait <= rsp_wait - 1;
         end else begin
            rsp_wait <= 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done && reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[viewport_present_rect] ERROR");
         $finish;
      end
   end

   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 3))
         0: return DIM_W'($urandom_range(1, 4095));
         1: return DIM_W'($urandom_range(0, 4095));
         default: return DIM_W'($urandom_range(1, 1024));
      endcase
   endfunction

   row_type directed[$];

   initial begin
      rect_type none;
      none = '0;
      shadow_scr_w = 640; shadow_scr_h = 480; shadow_mode = MODE_CORE;
      shadow_aspect = 0; shadow_hdmi = 0; shadow_offx = 0; shadow_offy = 0;
      shadow_rot = 0;
      // After reset: 640x480 in frame ratio; 4:3 frame fills the screen
      directed.push_back('{12'd320, 12'd240, 1'b1, '{14'd0, 14'd0, 13'd640, 13'd480, 1'b0}});
      directed.push_back('{12'd4095, 12'd4095, 1'b0, none});
      directed.push_back('{12'd1, 12'd1, 1'b0, none});
      directed.push_back('{12'd0, 12'd0, 1'b0, none});
      directed.push_back('{12'd4095, 12'd1, 1'b0, none});
      directed.push_back('{12'd1, 12'd4095, 1'b0, none});
      directed.push_back('{12'd2730, 12'd1365, 1'b0, none});
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 12; p++) begin
         if (p > 0) begin
            wait_idle();
            // Cycle through modes with extremes early, random later
            case (p)
               1: begin
                  write_reg(REG_MODE, MODE_NATIVE); write_reg(REG_SCREEN_W, 4096);
                  write_reg(REG_SCREEN_H, 4096); write_reg(REG_OFFSET_X, 8'h80);
                  write_reg(REG_OFFSET_Y, 8'h7f); write_reg(REG_ROTATION, 1);
               end
               2: begin
                  write_reg(REG_MODE, MODE_CROP); write_reg(REG_SCREEN_W, 0);
                  write_reg(REG_SCREEN_H, 1); write_reg(REG_ASPECT, 20'hfffff);
               end
               3: begin
                  write_reg(REG_HDMI, 1); write_reg(REG_SCREEN_W, 8191);
                  write_reg(REG_SCREEN_H, 8191); write_reg(REG_ROTATION, 2);
               end
               4: begin
                  write_reg(REG_MODE, MODE_FULL); write_reg(REG_OFFSET_X, 8'h7f);
                  write_reg(REG_OFFSET_Y, 8'h80); write_reg(REG_ROTATION, 3);
               end
               5: begin
                  write_reg(REG_MODE, MODE_FRAME); write_reg(REG_SCREEN_W, 1920);
                  write_reg(REG_SCREEN_H, 1080);
               end
               6: begin
                  write_reg(REG_MODE, 3'd7); write_reg(REG_ASPECT, 20'h15555);
                  write_reg(REG_HDMI, 0); write_reg(REG_OFFSET_X, 8'hc0);
               end
               default: begin
                  write_reg(REG_SCREEN_W, $urandom_range(0, 8191));
                  write_reg(REG_SCREEN_H, $urandom_range(0, 8191));
                  write_reg(REG_MODE, $urandom_range(0, 7));
                  write_reg(REG_ASPECT, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20'hfffff));
                  write_reg(REG_HDMI, $urandom_range(0, 1));
                  write_reg(REG_OFFSET_X, $urandom_range(0, 255));
                  write_reg(REG_OFFSET_Y, $urandom_range(0, 255));
                  write_reg(REG_ROTATION, $urandom_range(0, 3));
               end
            endcase
         end
         if (p == 0)
            foreach (directed[i])
               send_request(directed[i].fw, directed[i].fh, directed[i].typed, directed[i].rect);
         else
            repeat (p < 7 ? 40 : 190) send_request(rand_dim(), rand_dim(), 1'b0, none);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0)
         $display("[viewport_present_rect] OK");
      else
         $display("[viewport_present_rect] ERROR");
      $finish;
   end
endmodule
